/* design/ptzhex_pkg.sv */
// Package with the types, constants and helper functions of the PTZ command hex decoder.
package ptzhex_pkg;

  localparam int unsigned CountWidth = 5;
  localparam int unsigned ByteIdxWidth = 3;

  // Digit count that makes a complete frame, and the count's saturation value.
  localparam logic [CountWidth-1:0] DIGITS_PER_FRAME = 5'd16;
  localparam logic [CountWidth-1:0] COUNT_SAT        = 5'd17;

  // Byte positions inside the frame, counted from zero.
  localparam logic [ByteIdxWidth-1:0] CODE_BYTE  = 3'd3;
  localparam logic [ByteIdxWidth-1:0] PAN_BYTE   = 3'd4;
  localparam logic [ByteIdxWidth-1:0] TILT_BYTE  = 3'd5;
  localparam logic [ByteIdxWidth-1:0] ZOOM_BYTE  = 3'd6;
  localparam logic [ByteIdxWidth-1:0] CHECK_BYTE = 3'd7;

  // Direction bits of the command code byte.
  localparam logic [7:0] PAN_RIGHT = 8'h01;
  localparam logic [7:0] PAN_LEFT  = 8'h02;
  localparam logic [7:0] TILT_DOWN = 8'h04;
  localparam logic [7:0] TILT_UP   = 8'h08;
  localparam logic [7:0] ZOOM_IN   = 8'h10;
  localparam logic [7:0] ZOOM_OUT  = 8'h20;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_CHAR  = 2'd1,
    STATUS_BAD_COUNT = 2'd2,
    STATUS_BAD_SUM   = 2'd3
  } status_t;

  typedef logic signed [1:0] dir_t;

  localparam dir_t DIR_POS  = 2'sd1;
  localparam dir_t DIR_NEG  = -2'sd1;
  localparam dir_t DIR_NONE = 2'sd0;

  // Decoded character: a valid flag and the nibble value.
  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } nibble_t;

  // True for space, tab, carriage return and line feed.
  function automatic logic is_space(input logic [7:0] c);
    logic res;
    case (c) inside
      8'h20, 8'h09, 8'h0D, 8'h0A: res = 1'b1;
      default:                    res = 1'b0;
    endcase
    return res;
  endfunction

  // Converts one ASCII hex digit of either case; anything else reads as zero.
  function automatic nibble_t hex_nibble(input logic [7:0] c);
    nibble_t res;
    case (c) inside
      [8'h30:8'h39]: res = '{is_hex: 1'b1, value: 4'(c - 8'h30)};
      [8'h41:8'h46]: res = '{is_hex: 1'b1, value: 4'(c - 8'h37)};
      [8'h61:8'h66]: res = '{is_hex: 1'b1, value: 4'(c - 8'h57)};
      default:       res = '{is_hex: 1'b0, value: 4'd0};
    endcase
    return res;
  endfunction

  // Direction from the code byte; the positive bit wins over the negative one.
  function automatic dir_t dir_of(input logic [7:0] code, input logic [7:0] pos_bit,
                                  input logic [7:0] neg_bit);
    dir_t res;
    if ((code & pos_bit) != 8'h00) begin
      res = DIR_POS;
    end else if ((code & neg_bit) != 8'h00) begin
      res = DIR_NEG;
    end else begin
      res = DIR_NONE;
    end
    return res;
  endfunction

endpackage

/* design/ptz_command_hex_decoder.sv */
// PTZ command hex decoder: parses the hex text of an 8-byte pan-tilt-zoom command.
//
// Usage:
//   The input channel (in_valid, in_ch, in_last, in_stall) carries one ASCII
//   character per beat. Space, tab, CR and LF are skipped; every other
//   character counts as one digit, and hex digit pairs form the 8 frame bytes.
//   A beat with in_last high closes the string, and one result beat follows on
//   the output channel (out_valid, out_status, directions, speeds, out_stall).
//   The result of a last character is registered and valid in the cycle
//   after its acceptance. Throughput: one character per cycle, but for a
//   stalled last character; each character is decoded and folded into the
//   frame state on acceptance, and the result is held in one output register.
//   When the receiver stalls, the result stays in the output register. Further
//   characters are still accepted; only a character marked last is stalled
//   until the waiting result is taken.
//   A non-zero status (bad character, wrong digit count, checksum mismatch)
//   comes with all direction and speed fields at zero.
//   Reset (rst_n low, synchronous) empties the output register and clears the
//   digit count, pending nibble, running sum and bad-character flag. The frame
//   byte registers are not reset; they are always rewritten before a read.
module ptz_command_hex_decoder (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [7:0]               in_ch,
  input  logic                     in_last,
  output logic                     in_stall,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output ptzhex_pkg::dir_t         out_pan_dir,
  output ptzhex_pkg::dir_t         out_tilt_dir,
  output ptzhex_pkg::dir_t         out_zoom_dir,
  output logic [7:0]               out_pan_speed,
  output logic [7:0]               out_tilt_speed,
  output logic [3:0]               out_zoom_speed,
  input  logic                     out_stall
);
  import ptzhex_pkg::*;

  // Frame state.
  logic [CountWidth-1:0] count_r, count_nxt;
  logic [3:0]            high_r, high_nxt;
  logic [7:0]            sum_r, sum_nxt;
  logic                  bad_r, bad_nxt;
  logic [7:0]            frame_r [3:7];

  // Output register.
  logic        out_valid_r;
  status_t     status_r, status_nxt;
  dir_t        pan_dir_r, pan_dir_nxt;
  dir_t        tilt_dir_r, tilt_dir_nxt;
  dir_t        zoom_dir_r, zoom_dir_nxt;
  logic [7:0]  pan_speed_r, pan_speed_nxt;
  logic [7:0]  tilt_speed_r, tilt_speed_nxt;
  logic [3:0]  zoom_speed_r, zoom_speed_nxt;

  logic                    in_accept;
  logic                    done;
  nibble_t                 nib;
  logic                    counted;
  logic                    byte_wr;
  logic [ByteIdxWidth-1:0] byte_idx;
  logic [7:0]              byte_val;
  logic [7:0]              view [3:7];

  // Only a closing character needs the output register; it waits while a
  // result is held and the receiver stalls.
  assign in_stall  = in_last & out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign done      = in_accept & in_last;

  // Character decode and frame state update.
  always_comb begin
    nib       = hex_nibble(in_ch);
    counted   = in_accept & ~is_space(in_ch);
    byte_idx  = count_r[ByteIdxWidth:1];
    byte_val  = {high_r, nib.value};
    byte_wr   = counted & (count_r < DIGITS_PER_FRAME) & count_r[0];
    count_nxt = count_r;
    high_nxt  = high_r;
    sum_nxt   = sum_r;
    bad_nxt   = bad_r;
    if (counted) begin
      if (!nib.is_hex) begin
        bad_nxt = 1'b1;
      end
      if (count_r < DIGITS_PER_FRAME && !count_r[0]) begin
        high_nxt = nib.value;
      end
      if (byte_wr && byte_idx != CHECK_BYTE) begin
        sum_nxt = sum_r + byte_val;
      end
      if (count_r < COUNT_SAT) begin
        count_nxt = count_r + 5'd1;
      end
    end
  end

  // Frame bytes as they stand after this character.
  always_comb begin
    for (int i = 3; i <= 7; i++) begin
      view[i] = (byte_wr && byte_idx == ByteIdxWidth'(i)) ? byte_val : frame_r[i];
    end
  end

  // Result of a closing character, checked in priority order.
  always_comb begin
    status_nxt     = STATUS_OK;
    pan_dir_nxt    = DIR_NONE;
    tilt_dir_nxt   = DIR_NONE;
    zoom_dir_nxt   = DIR_NONE;
    pan_speed_nxt  = 8'd0;
    tilt_speed_nxt = 8'd0;
    zoom_speed_nxt = 4'd0;
    if (count_nxt != DIGITS_PER_FRAME) begin
      status_nxt = STATUS_BAD_COUNT;
    end else if (bad_nxt) begin
      status_nxt = STATUS_BAD_CHAR;
    end else if (sum_nxt != view[CHECK_BYTE]) begin
      status_nxt = STATUS_BAD_SUM;
    end else begin
      pan_dir_nxt    = dir_of(view[CODE_BYTE], PAN_RIGHT, PAN_LEFT);
      tilt_dir_nxt   = dir_of(view[CODE_BYTE], TILT_DOWN, TILT_UP);
      zoom_dir_nxt   = dir_of(view[CODE_BYTE], ZOOM_IN, ZOOM_OUT);
      pan_speed_nxt  = view[PAN_BYTE];
      tilt_speed_nxt = view[TILT_BYTE];
      zoom_speed_nxt = view[ZOOM_BYTE][7:4];
    end
  end

  // Frame state registers; a closing character starts a new frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      high_r  <= '0;
      sum_r   <= '0;
      bad_r   <= 1'b0;
    end else if (done) begin
      count_r <= '0;
      high_r  <= '0;
      sum_r   <= '0;
      bad_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      high_r  <= high_nxt;
      sum_r   <= sum_nxt;
      bad_r   <= bad_nxt;
    end
  end

  // Frame byte registers; only the bytes that the result reads are kept.
  always_ff @(posedge clk) begin
    for (int i = 3; i <= 7; i++) begin
      if (byte_wr && byte_idx == ByteIdxWidth'(i)) begin
        frame_r[i] <= byte_val;
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload, loaded when a closing character is accepted.
  always_ff @(posedge clk) begin
    if (done) begin
      status_r     <= status_nxt;
      pan_dir_r    <= pan_dir_nxt;
      tilt_dir_r   <= tilt_dir_nxt;
      zoom_dir_r   <= zoom_dir_nxt;
      pan_speed_r  <= pan_speed_nxt;
      tilt_speed_r <= tilt_speed_nxt;
      zoom_speed_r <= zoom_speed_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_pan_dir    = pan_dir_r;
  assign out_tilt_dir   = tilt_dir_r;
  assign out_zoom_dir   = zoom_dir_r;
  assign out_pan_speed  = pan_speed_r;
  assign out_tilt_speed = tilt_speed_r;
  assign out_zoom_speed = zoom_speed_r;

  // A closing character always produces a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_valid_r)
    else $error("closing character did not produce a result");

  // The frame state is clear after a closing character.
  a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (count_r == '0 && sum_r == '0 && bad_r == 1'b0 && high_r == '0))
    else $error("frame state not cleared after a result");

  // The digit count never passes its saturation value.
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_SAT)
    else $error("digit count above saturation");

  // An error result carries no direction or speed.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != STATUS_OK) |->
      (pan_dir_r == DIR_NONE && tilt_dir_r == DIR_NONE && zoom_dir_r == DIR_NONE &&
       pan_speed_r == 8'd0 && tilt_speed_r == 8'd0 && zoom_speed_r == 4'd0))
    else $error("error result with non-zero fields");

  // A held, stalled result is not overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(status_r)))
    else $error("stalled result was lost or overwritten");

endmodule

/* bench/ptz_command_hex_decoder_tb.sv */
// Self-checking testbench for the PTZ command hex decoder, with driver, monitor and predictor.
`timescale 1ns / 100ps

module ptz_command_hex_decoder_tb;
  import ptzhex_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PhaseChars  = 120;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned DrainCycles = 8;

  // Idle modes for the two channels.
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // Kinds of random command strings.
  typedef enum int {
    STR_GOOD,
    STR_BAD_SUM,
    STR_BAD_CHAR,
    STR_BAD_COUNT,
    STR_NOISE
  } str_kind_t;

  typedef struct {
    logic [7:0] ch;
    logic       is_last;
  } char_beat_t;

  typedef struct {
    status_t    status;
    dir_t       pan_dir;
    dir_t       tilt_dir;
    dir_t       zoom_dir;
    logic [7:0] pan_speed;
    logic [7:0] tilt_speed;
    logic [3:0] zoom_speed;
  } ptz_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic [7:0]          in_ch;
  logic                in_last;
  logic                in_stall;
  logic                out_valid;
  logic [1:0]          out_status;
  dir_t                out_pan_dir;
  dir_t                out_tilt_dir;
  dir_t                out_zoom_dir;
  logic [7:0]          out_pan_speed;
  logic [7:0]          out_tilt_speed;
  logic [3:0]          out_zoom_speed;
  logic                out_stall;

  char_beat_t          pending_chars[$];
  ptz_result_t         expected_results[$];
  idle_mode_t          idle_mode;
  int unsigned         errors;
  int unsigned         chars_accepted;
  int unsigned         results_seen;
  int unsigned         cycle_count;

  // Decoder state as the predictor sees it.
  logic [4:0]          pred_digits;
  logic [3:0]          pred_high_nib;
  logic [7:0]          pred_frame[8];
  logic [7:0]          pred_sum;
  logic                pred_bad_char;

  ptz_command_hex_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ch          (in_ch),
    .in_last        (in_last),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_pan_dir    (out_pan_dir),
    .out_tilt_dir   (out_tilt_dir),
    .out_zoom_dir   (out_zoom_dir),
    .out_pan_speed  (out_pan_speed),
    .out_tilt_speed (out_tilt_speed),
    .out_zoom_speed (out_zoom_speed),
    .out_stall      (out_stall)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

  function automatic logic is_hex_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic dir_t pick_dir(input logic [7:0] code, input logic [7:0] pos_mask,
                                    input logic [7:0] neg_mask);
    dir_t d;
    d = DIR_NONE;
    if ((code & pos_mask) != 8'h00) begin
      d = DIR_POS;
    end else if ((code & neg_mask) != 8'h00) begin
      d = DIR_NEG;
    end
    return d;
  endfunction

  // Folds one character into the predicted state; returns 1 when a result is due.
  function automatic bit fold_char(input logic [7:0] c, input logic is_last,
                                   output ptz_result_t res);
    logic [3:0] nib;
    logic [7:0] b;
    logic [7:0] code;
    res.status     = STATUS_OK;
    res.pan_dir    = DIR_NONE;
    res.tilt_dir   = DIR_NONE;
    res.zoom_dir   = DIR_NONE;
    res.pan_speed  = 8'h00;
    res.tilt_speed = 8'h00;
    res.zoom_speed = 4'h0;
    if (!is_blank(c)) begin
      if (c >= 8'h30 && c <= 8'h39) begin
        nib = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
        nib = 4'(c - 8'h41 + 8'd10);
      end else if (c >= 8'h61 && c <= 8'h66) begin
        nib = 4'(c - 8'h61 + 8'd10);
      end else begin
        nib = 4'h0;
        pred_bad_char = 1'b1;
      end
      if (pred_digits < DIGITS_PER_FRAME) begin
        if (!pred_digits[0]) begin
          pred_high_nib = nib;
        end else begin
          b = {pred_high_nib, nib};
          pred_frame[pred_digits[3:1]] = b;
          if (pred_digits[3:1] != CHECK_BYTE) begin
            pred_sum = pred_sum + b;
          end
        end
      end
      if (pred_digits < COUNT_SAT) begin
        pred_digits = pred_digits + 5'd1;
      end
    end
    if (!is_last) begin
      return 1'b0;
    end
    // Count first, then bad characters, then the checksum.
    if (pred_digits != DIGITS_PER_FRAME) begin
      res.status = STATUS_BAD_COUNT;
    end else if (pred_bad_char) begin
      res.status = STATUS_BAD_CHAR;
    end else if (pred_sum != pred_frame[CHECK_BYTE]) begin
      res.status = STATUS_BAD_SUM;
    end else begin
      code           = pred_frame[CODE_BYTE];
      res.pan_dir    = pick_dir(code, PAN_RIGHT, PAN_LEFT);
      res.tilt_dir   = pick_dir(code, TILT_DOWN, TILT_UP);
      res.zoom_dir   = pick_dir(code, ZOOM_IN, ZOOM_OUT);
      res.pan_speed  = pred_frame[PAN_BYTE];
      res.tilt_speed = pred_frame[TILT_BYTE];
      res.zoom_speed = pred_frame[ZOOM_BYTE][7:4];
    end
    pred_digits   = 5'd0;
    pred_high_nib = 4'h0;
    pred_sum      = 8'h00;
    pred_bad_char = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] hex_text(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = 8'h30 + 8'(n);
    end else begin
      c = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    end
    return c;
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    c = 8'(($urandom_range(0, 255)));
    while (is_hex_char(c) || is_blank(c)) begin
      c = 8'(($urandom_range(0, 255)));
    end
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    logic [7:0] blanks[4];
    blanks = '{8'h20, 8'h09, 8'h0D, 8'h0A};
    return blanks[$urandom_range(0, 3)];
  endfunction

  // Queues a string of characters; the final one carries the last flag.
  task automatic queue_text(input logic [7:0] text[$]);
    char_beat_t beat;
    foreach (text[i]) begin
      beat.ch      = text[i];
      beat.is_last = (i == text.size() - 1);
      pending_chars.insert(pending_chars.size(), beat);
    end
  endtask

  // Builds one random command string of the given kind.
  task automatic queue_command(input str_kind_t kind, output int unsigned n_chars);
    logic [7:0] bytes[8];
    logic [7:0] digits[$];
    logic [7:0] text[$];
    int unsigned n_digits;
    int unsigned pos;
    digits = {};
    text   = {};
    if (kind == STR_NOISE) begin
      repeat ($urandom_range(1, 20)) begin
        digits.insert(digits.size(), 8'(($urandom_range(0, 255))));
      end
    end else begin
      for (int i = 0; i < 7; i++) bytes[i] = 8'(($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) bytes[CODE_BYTE] = bytes[CODE_BYTE] & 8'h3F;
      bytes[CHECK_BYTE] = 8'h00;
      for (int i = 0; i < 7; i++) bytes[CHECK_BYTE] = bytes[CHECK_BYTE] + bytes[i];
      if (kind == STR_BAD_SUM) begin
        bytes[CHECK_BYTE] = bytes[CHECK_BYTE] ^ 8'(($urandom_range(1, 255)));
      end
      for (int i = 0; i < 8; i++) begin
        digits.insert(digits.size(), hex_text(bytes[i][7:4]));
        digits.insert(digits.size(), hex_text(bytes[i][3:0]));
      end
      if (kind == STR_BAD_CHAR) begin
        repeat ($urandom_range(1, 2)) digits[$urandom_range(0, 15)] = junk_char();
      end else if (kind == STR_BAD_COUNT) begin
        n_digits = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(17, 24);
        while (digits.size() > n_digits) void'(digits.pop_back());
        while (digits.size() < n_digits) begin
          digits.insert(digits.size(),
                        $urandom_range(0, 7) ? hex_text(4'(($urandom_range(0, 15))))
                                             : junk_char());
        end
      end
    end
    // Sprinkle whitespace between digits, and sometimes end on a blank.
    foreach (digits[i]) begin
      if ($urandom_range(0, 99) < 12) text.insert(text.size(), blank_char());
      text.insert(text.size(), digits[i]);
    end
    if (text.size() == 0 || $urandom_range(0, 99) < 15) text.insert(text.size(), blank_char());
    pos = text.size();
    queue_text(text);
    n_chars = pos;
  endtask

  function automatic bit roll_idle(input bit sender_side);
    int unsigned pct;
    case (idle_mode)
      IDLE_SENDER:   pct = sender_side ? 65 : 0;
      IDLE_RECEIVER: pct = sender_side ? 0 : 65;
      IDLE_BOTH:     pct = 37;
      default:       pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  // Driver: predicts each accepted character and offers the next one.
  always @(posedge clk) begin
    ptz_result_t res;
    char_beat_t  beat;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        chars_accepted++;
        if (fold_char(in_ch, in_last, res)) begin
          expected_results.insert(expected_results.size(), res);
        end
      end
      if (!in_valid || !in_stall) begin
        if (pending_chars.size() > 0 && !roll_idle(1'b1)) begin
          beat = pending_chars.pop_front();
          in_valid <= 1'b1;
          in_ch    <= beat.ch;
          in_last  <= beat.is_last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    ptz_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result beat with no prediction waiting");
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
          if (out_pan_dir !== want.pan_dir) begin
            $error("pan_dir: expected %0d, got %0d", want.pan_dir, out_pan_dir);
            errors++;
          end
          if (out_tilt_dir !== want.tilt_dir) begin
            $error("tilt_dir: expected %0d, got %0d", want.tilt_dir, out_tilt_dir);
            errors++;
          end
          if (out_zoom_dir !== want.zoom_dir) begin
            $error("zoom_dir: expected %0d, got %0d", want.zoom_dir, out_zoom_dir);
            errors++;
          end
          if (out_pan_speed !== want.pan_speed) begin
            $error("pan_speed: expected %0d, got %0d", want.pan_speed, out_pan_speed);
            errors++;
          end
          if (out_tilt_speed !== want.tilt_speed) begin
            $error("tilt_speed: expected %0d, got %0d", want.tilt_speed, out_tilt_speed);
            errors++;
          end
          if (out_zoom_speed !== want.zoom_speed) begin
            $error("zoom_speed: expected %0d, got %0d", want.zoom_speed, out_zoom_speed);
            errors++;
          end
        end
      end
      out_stall <= roll_idle(1'b0);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus: directed strings, then random phases, then drain.
  initial begin
    logic [7:0]  text[$];
    string       directed;
    int unsigned phase_chars;
    int unsigned n_chars;
    int unsigned roll;
    str_kind_t   kind;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_ch         = 8'h00;
    in_last       = 1'b0;
    out_stall     = 1'b0;
    idle_mode     = IDLE_NONE;
    errors        = 0;
    chars_accepted = 0;
    results_seen  = 0;
    cycle_count   = 0;
    pred_digits   = 5'd0;
    pred_high_nib = 4'h0;
    pred_sum      = 8'h00;
    pred_bad_char = 1'b0;
    foreach (pred_frame[i]) pred_frame[i] = 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Mixed case, every direction with both bits set, top speeds, whitespace last.
    directed = "a5 00\t01 3F\rff FF f0 D3\n";
    text = {};
    for (int i = 0; i < directed.len(); i++) text.insert(text.size(), directed[i]);
    queue_text(text);
    // A lone bad character closes a short string, then a lone blank closes an empty one.
    text = {8'h5A};
    queue_text(text);
    text = {8'h20};
    queue_text(text);
    while (pending_chars.size() > 0) @(posedge clk);

    for (int p = 0; p < NumPhases; p++) begin
      idle_mode   = idle_mode_t'(p % 4);
      phase_chars = 0;
      while (phase_chars < PhaseChars) begin
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          kind = STR_GOOD;
        end else if (roll < 70) begin
          kind = STR_BAD_SUM;
        end else if (roll < 80) begin
          kind = STR_BAD_CHAR;
        end else if (roll < 90) begin
          kind = STR_BAD_COUNT;
        end else begin
          kind = STR_NOISE;
        end
        queue_command(kind, n_chars);
        phase_chars += n_chars;
      end
      while (pending_chars.size() > 0) @(posedge clk);
    end

    while (in_valid || expected_results.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Run covered %0d characters and %0d result beats: good, checksum, bad-character,",
             chars_accepted, results_seen);
    $display("count and noise strings under no idling, sender gaps, receiver stalls and both.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ptzhex_pkg.sv
design/ptz_command_hex_decoder.sv
bench/ptz_command_hex_decoder_tb.sv
